>>> design/premultiplied_pixel_store_core_assert.svh
// Assertion macros used by the checker file.
`ifndef PREMULTIPLIED_PIXEL_STORE_CORE_ASSERT_SVH
`define PREMULTIPLIED_PIXEL_STORE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pixel store assertion failed");

// Next-cycle implication, disabled during reset.
`define PPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel store assertion failed");

`endif

>>> design/pps_pkg.sv
package pps_pkg;

  localparam int DIM_W = 9;
  localparam int CH_W = 8;
  localparam logic [CH_W-1:0] CODE_MAX = 8'hFF;
  localparam logic [15:0] BLEND_ROUND = 16'd127;
  localparam logic [4:0] DIV_STEPS = 5'd17;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_BLEND = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_WIDTH    = 2'd2,
    REG_HEIGHT   = 2'd3
  } cfg_reg_t;

  // Exact floor(x / 255) for x below 65280.
  function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + {8'd0, x[15:8]} + 16'd1;
    return t[15:8];
  endfunction

endpackage

>>> design/premultiplied_pixel_store_core.sv
// A write, a blend, an inside read and an outside coordinate each give one result; an inside
// read skips the division when the stored alpha is zero. Clear writes width*height words
// before its result. One shared multiply-add unit works channel by channel and the
// read divides bit-serially, one quotient bit per cycle. The next request is taken in the
// cycle after a result is produced, while that result may still wait on the output.
// After reset all MAX_WIDTH*MAX_HEIGHT words of the store are swept to zero before requests.
module premultiplied_pixel_store_core
  import pps_pkg::*;
#(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [7:0]        red_in,
  input  logic [7:0]        green_in,
  input  logic [7:0]        blue_in,
  input  logic [7:0]        alpha_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              status,
  output logic [7:0]        red_out,
  output logic [7:0]        green_out,
  output logic [7:0]        blue_out,
  output logic [7:0]        alpha_out,
  output logic [31:0]       change_count
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_LOCATE, S_ADDR, S_FETCH, S_LOAD, S_MAC, S_WRITE,
    S_FILL, S_DIV_SETUP, S_DIV_STEP, S_FINISH
  } state_t;

  state_t state;
  logic signed [15:0] origin_x, origin_y;
  logic [DIM_W-1:0] layer_width, layer_height;
  cmd_t cmd;
  logic signed [15:0] x_q, y_q;
  logic [7:0] r_q, g_q, b_q, a_q;
  logic signed [16:0] bx, by;
  logic [ADDR_W-1:0] addr;
  logic [31:0] dst, word;
  logic [15:0] acc;
  logic [1:0] phase, ch;
  logic [16:0] num, quo;
  logic [8:0] rem;
  logic [4:0] bit_cnt;
  logic [CNT_W-1:0] fill_idx, fill_n;
  logic [31:0] counter;
  logic res_status;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic in_layer;
  logic [17:0] addr_sum;
  logic [7:0] src_c, dst_c, mul_a, mul_b;
  logic [15:0] mul_p, acc_next;
  logic [9:0] rem_sh;
  logic [8:0] den;
  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0] ram_wdata, ram_rdata;

  always_comb begin
    w_eff = (int'(layer_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : layer_width;
    h_eff = (int'(layer_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : layer_height;
    in_layer = !bx[16] && !by[16] && (bx[15:0] < {7'd0, w_eff}) &&
               (by[15:0] < {7'd0, h_eff});
    addr_sum = 18'(by[8:0]) * 18'(w_eff) + 18'(bx[8:0]);
    unique case (ch)
      2'd0: src_c = b_q;
      2'd1: src_c = g_q;
      2'd2: src_c = r_q;
      default: src_c = CODE_MAX;
    endcase
    dst_c = (cmd == CMD_BLEND) ? dst[ch*8 +: 8] : 8'd0;
    if (phase == 2'd0) begin
      mul_a = src_c;
      mul_b = a_q;
    end else begin
      mul_a = dst_c;
      mul_b = CODE_MAX - a_q;
    end
    mul_p = mul_a * mul_b;
    acc_next = ((phase == 2'd0) ? ((cmd == CMD_BLEND) ? BLEND_ROUND : 16'd0) : acc) + mul_p;
    den = {dst[31:24], 1'b0};
    rem_sh = {rem, num[16]};
    ram_we = (state == S_INIT) || (state == S_WRITE) ||
             ((state == S_FILL) && (fill_idx < fill_n));
    ram_waddr = (state == S_WRITE) ? addr : fill_idx[ADDR_W-1:0];
    ram_wdata = (state == S_INIT) ? 32'd0 : word;
  end

  pps_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      origin_x <= '0;
      origin_y <= '0;
      layer_width <= 9'd256;
      layer_height <= 9'd256;
      counter <= '0;
      fill_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ORIGIN_X: origin_x <= cfg_data;
          REG_ORIGIN_Y: origin_y <= cfg_data;
          REG_WIDTH:    layer_width <= cfg_data[DIM_W-1:0];
          REG_HEIGHT:   layer_height <= cfg_data[DIM_W-1:0];
        endcase
      end
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          fill_idx <= fill_idx + 1'b1;
          if (fill_idx == CNT_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd <= cmd_t'(command);
            x_q <= pos_x;
            y_q <= pos_y;
            r_q <= red_in;
            g_q <= green_in;
            b_q <= blue_in;
            a_q <= alpha_in;
            state <= S_LOCATE;
          end
        end
        S_LOCATE: begin
          bx <= {x_q[15], x_q} - {origin_x[15], origin_x};
          by <= {y_q[15], y_q} - {origin_y[15], origin_y};
          state <= S_ADDR;
        end
        S_ADDR: begin
          addr <= ADDR_W'(addr_sum);
          res_status <= 1'b0;
          ch <= 2'd0;
          phase <= 2'd0;
          word <= {a_q, 24'd0};
          if (cmd == CMD_CLEAR || (in_layer && cmd == CMD_WRITE)) begin
            state <= S_MAC;
          end else if (!in_layer) begin
            res_status <= 1'b1;
            state <= S_FINISH;
          end else begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          dst <= ram_rdata;
          if (cmd == CMD_BLEND) begin
            state <= S_MAC;
          end else if (ram_rdata[31:24] == 8'd0) begin
            word <= 32'd0;
            state <= S_FINISH;
          end else begin
            word <= {ram_rdata[31:24], 24'd0};
            state <= S_DIV_SETUP;
          end
        end
        S_MAC: begin
          if (phase == 2'd2) begin
            word[ch*8 +: 8] <= div255(acc);
            phase <= 2'd0;
            ch <= ch + 1'b1;
            if (ch == ((cmd == CMD_BLEND) ? 2'd3 : 2'd2)) begin
              if (cmd == CMD_CLEAR) begin
                fill_idx <= '0;
                fill_n <= CNT_W'(w_eff) * CNT_W'(h_eff);
                state <= S_FILL;
              end else begin
                state <= S_WRITE;
              end
            end
          end else begin
            acc <= acc_next;
            phase <= phase + 1'b1;
          end
        end
        S_WRITE: begin
          counter <= counter + 1'b1;
          state <= S_FINISH;
        end
        S_FILL: begin
          if (fill_idx < fill_n) begin
            fill_idx <= fill_idx + 1'b1;
          end else begin
            counter <= counter + 1'b1;
            state <= S_FINISH;
          end
        end
        S_DIV_SETUP: begin
          num <= {dst[ch*8 +: 8], 9'd0} - {8'd0, dst[ch*8 +: 8], 1'b0} + {9'd0, dst[31:24]};
          rem <= '0;
          quo <= '0;
          bit_cnt <= DIV_STEPS;
          state <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          if (bit_cnt == 5'd0) begin
            word[ch*8 +: 8] <= (|quo[16:8]) ? CODE_MAX : quo[7:0];
            ch <= ch + 1'b1;
            state <= (ch == 2'd2) ? S_FINISH : S_DIV_SETUP;
          end else begin
            num <= {num[15:0], 1'b0};
            bit_cnt <= bit_cnt - 1'b1;
            if (rem_sh >= {1'b0, den}) begin
              rem <= 9'(rem_sh - {1'b0, den});
              quo <= {quo[15:0], 1'b1};
            end else begin
              rem <= rem_sh[8:0];
              quo <= {quo[15:0], 1'b0};
            end
          end
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status <= res_status;
            change_count <= counter;
            if (cmd == CMD_READ && !res_status) begin
              alpha_out <= word[31:24];
              red_out <= word[23:16];
              green_out <= word[15:8];
              blue_out <= word[7:0];
            end else begin
              alpha_out <= 8'd0;
              red_out <= 8'd0;
              green_out <= 8'd0;
              blue_out <= 8'd0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/pps_ram.sv
module pps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/pps_checker.sv
`include "premultiplied_pixel_store_core_assert.svh"

module pps_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        status,
  input logic [7:0]  red_out,
  input logic [7:0]  green_out,
  input logic [7:0]  blue_out,
  input logic [7:0]  alpha_out,
  input logic [31:0] change_count
);

  logic rgb_blank;
  logic color_blank;

  assign rgb_blank = (red_out == 8'd0) && (green_out == 8'd0) && (blue_out == 8'd0);
  assign color_blank = rgb_blank && (alpha_out == 8'd0);

  // A request keeps the block busy for at least the next cycle.
  `PPS_ASSERT_NEXT(busy_after_request, in_valid && !in_stall, in_stall)
  // Outside coordinates never report a color.
  `PPS_ASSERT_NOW(outside_is_blank, out_valid && status, color_blank)
  // Zero alpha always comes with zero color.
  `PPS_ASSERT_NOW(clear_alpha_is_blank, out_valid && (alpha_out == 8'd0), rgb_blank)
  // A stalled result holds.
  `PPS_ASSERT_NEXT(result_holds, out_valid && out_stall, out_valid && $stable({status, change_count}))

endmodule

bind premultiplied_pixel_store_core pps_checker u_pps_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .red_out     (red_out),
  .green_out   (green_out),
  .blue_out    (blue_out),
  .alpha_out   (alpha_out),
  .change_count(change_count)
);
